>>> design/rthlp_pkg.sv
// ----------------------------------------------------------------------------
// rthlp_pkg: shared definitions for the RGB to hue/luma palette converter
// Fixed-point widths, conversion weights, CORDIC arctangent table, gray bound
// table and hue decision boundaries.
// ----------------------------------------------------------------------------
package rthlp_pkg;

   localparam int COLOR_W   = 8;
   localparam int THRESH_W  = 7;
   localparam int THRESH_NUM = 1 << THRESH_W;
   localparam int HUE_W     = 4;
   localparam int LUMA_W    = 4;

   // Luma in units of 1/255 with 16 fraction bits.
   localparam int YQ_W   = 24;
   localparam int DIFF_W = 25;
   localparam int PROD_W = 42;
   localparam int COMP_W = 25;
   localparam int SQ_W   = 48;
   localparam int CHROMA_W = 49;

   localparam int Y_R_WEIGHT = 19595;
   localparam int Y_G_WEIGHT = 38470;
   localparam int Y_B_WEIGHT = 7471;
   localparam logic signed [17:0] U_COEF = 18'sd32244;
   localparam logic signed [17:0] V_COEF = 18'sd57475;
   localparam int ROUND_SHIFT = 16;

   // CORDIC datapath.
   localparam int CORDIC_W        = 27;
   localparam int ACC_W           = 20;
   localparam int ANGLE_W         = 16;
   localparam int CORDIC_STEPS    = 16;
   localparam int STEP_IDX_W      = 4;
   localparam int STEPS_PER_STAGE = 2;
   localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
   // Pre-rotation register, the step stages and the angle rounding register.
   localparam int CORDIC_LAT      = CORDIC_STAGES + 2;
   localparam int GRAY_LAT        = 2;
   localparam int GRAY_DELAY      = CORDIC_LAT - GRAY_LAT;

   localparam logic [ACC_W-1:0] HALF_TURN = ACC_W'(1) << (ACC_W - 1);

   localparam logic [ACC_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      20'd131072, 20'd77376, 20'd40884, 20'd20753, 20'd10417, 20'd5213,
      20'd2607, 20'd1304, 20'd652, 20'd326, 20'd163, 20'd81, 20'd41,
      20'd20, 20'd10, 20'd5
   };

   // Hue entries sorted by angle, and the angle at which each step to the
   // next entry begins. A tie goes to the lower entry number.
   localparam int HUE_NUM = 14;
   localparam int HUE_POS_W = 4;
   localparam logic [HUE_W-1:0] HUE_ORDER [HUE_NUM] = '{
      4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd14,
      4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd7
   };
   localparam logic [ANGLE_W-1:0] HUE_CUT [HUE_NUM-1] = '{
      16'd6144, 16'd10240, 16'd14336, 16'd18432, 16'd22528, 16'd26625,
      16'd30720, 16'd34816, 16'd38912, 16'd45056, 16'd51200, 16'd55296,
      16'd59392
   };

   // Gray bound: floor((t*255*65536)^2 / 250000), reduced by the common
   // factor of sixteen.
   localparam logic [63:0] CHROMA_SCALE = 64'd65025;
   localparam int GRAY_SHIFT = 28;
   localparam logic [63:0] GRAY_DEN = 64'd15625;
   localparam logic [THRESH_W-1:0] GRAY_THRESH_RESET = 7'd50;

   typedef logic [THRESH_NUM-1:0][CHROMA_W-1:0] bound_table_type;

   function automatic bound_table_type gray_bound_table();
      bound_table_type tab;
      logic [63:0] num;
      for (int t = 0; t < THRESH_NUM; t++) begin
         num = (64'(t * t) * CHROMA_SCALE) << GRAY_SHIFT;
         tab[t] = CHROMA_W'(num / GRAY_DEN);
      end
      return tab;
   endfunction

   localparam bound_table_type GRAY_BOUND_TABLE = gray_bound_table();

   typedef struct packed {
      logic signed [COMP_W-1:0] uq;
      logic signed [COMP_W-1:0] vq;
      logic [LUMA_W-1:0]        luma;
   } yuv_type;

   typedef struct packed {
      logic              gray;
      logic [LUMA_W-1:0] luma;
   } side_type;

endpackage

>>> design/rthlp_yuv.sv
// ----------------------------------------------------------------------------
// rthlp_yuv: RGB to luma and scaled color differences
// Three register stages: weighted luma sum, difference times coefficient,
// symmetric rounding back to 16 fraction bits.
// ----------------------------------------------------------------------------
module rthlp_yuv (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [rthlp_pkg::COLOR_W-1:0] red,
   input  logic [rthlp_pkg::COLOR_W-1:0] green,
   input  logic [rthlp_pkg::COLOR_W-1:0] blue,
   output logic                          out_valid,
   output rthlp_pkg::yuv_type            out_yuv
);
   import rthlp_pkg::*;

   // Rounds half away from zero after dropping 16 fraction bits.
   function automatic logic signed [COMP_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] rnd;
      mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      rnd = (mag + (PROD_W'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
      return p[PROD_W-1] ? -COMP_W'(rnd) : COMP_W'(rnd);
   endfunction

   logic [2:0] valid_ff;

   logic [YQ_W-1:0]    yq_in, yq_ff;
   logic [COLOR_W-1:0] red_ff, blue_ff;

   logic signed [DIFF_W-1:0] du, dv;
   logic signed [PROD_W-1:0] prod_u_in, prod_v_in, prod_u_ff, prod_v_ff;
   logic [LUMA_W-1:0]        luma_s2_ff;

   yuv_type yuv_in, yuv_ff;

   always_comb begin
      yq_in = YQ_W'(32'(Y_R_WEIGHT) * 32'(red))
            + YQ_W'(32'(Y_G_WEIGHT) * 32'(green))
            + YQ_W'(32'(Y_B_WEIGHT) * 32'(blue));
   end

   always_comb begin
      du = $signed({1'b0, blue_ff, 16'd0}) - $signed({1'b0, yq_ff});
      dv = $signed({1'b0, red_ff, 16'd0}) - $signed({1'b0, yq_ff});
      prod_u_in = PROD_W'(du) * PROD_W'(U_COEF);
      prod_v_in = PROD_W'(dv) * PROD_W'(V_COEF);
   end

   always_comb begin
      yuv_in.uq   = round_q16(prod_u_ff);
      yuv_in.vq   = round_q16(prod_v_ff);
      yuv_in.luma = luma_s2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      yq_ff      <= yq_in;
      red_ff     <= red;
      blue_ff    <= blue;
      prod_u_ff  <= prod_u_in;
      prod_v_ff  <= prod_v_in;
      luma_s2_ff <= yq_ff[YQ_W-1 -: LUMA_W];
      yuv_ff     <= yuv_in;
   end

   assign out_valid = valid_ff[2];
   assign out_yuv   = yuv_ff;

endmodule

>>> design/rthlp_gray.sv
// ----------------------------------------------------------------------------
// rthlp_gray: chroma magnitude test
// Squares the color differences, compares their sum with the gray bound and
// delays the verdict and the luma level to line up with the angle pipeline.
// ----------------------------------------------------------------------------
module rthlp_gray (
   input  logic                           clock,
   input  rthlp_pkg::yuv_type             in_yuv,
   input  logic [rthlp_pkg::CHROMA_W-1:0] bound,
   output rthlp_pkg::side_type            out_side
);
   import rthlp_pkg::*;

   logic signed [2*COMP_W-1:0] pu, pv;
   logic [SQ_W-1:0]            sq_u_ff, sq_v_ff;
   logic [LUMA_W-1:0]          luma_ff;
   logic [CHROMA_W-1:0]        chroma;
   side_type                   side_in;
   side_type                   side_ff [GRAY_DELAY + 1];

   always_comb begin
      pu = in_yuv.uq * in_yuv.uq;
      pv = in_yuv.vq * in_yuv.vq;
      chroma = CHROMA_W'(sq_u_ff) + CHROMA_W'(sq_v_ff);
      side_in.gray = (chroma <= bound);
      side_in.luma = luma_ff;
   end

   always_ff @(posedge clock) begin
      sq_u_ff    <= SQ_W'(pu);
      sq_v_ff    <= SQ_W'(pv);
      luma_ff    <= in_yuv.luma;
      side_ff[0] <= side_in;
      for (int i = 1; i <= GRAY_DELAY; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   assign out_side = side_ff[GRAY_DELAY];

endmodule

>>> design/rthlp_cordic.sv
// ----------------------------------------------------------------------------
// rthlp_cordic: vectoring CORDIC angle of (U, V)
// A half-turn pre-rotation for the left half plane, sixteen vectoring steps
// two per register stage, and rounding to a 16-bit binary angle.
// ----------------------------------------------------------------------------
module rthlp_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [rthlp_pkg::COMP_W-1:0] in_x,
   input  logic signed [rthlp_pkg::COMP_W-1:0] in_y,
   output logic                                out_valid,
   output logic [rthlp_pkg::ANGLE_W-1:0]       out_angle
);
   import rthlp_pkg::*;

   logic                       valid_ff [CORDIC_STAGES + 2];
   logic signed [CORDIC_W-1:0] x_ff     [CORDIC_STAGES + 1];
   logic signed [CORDIC_W-1:0] y_ff     [CORDIC_STAGES + 1];
   logic [ACC_W-1:0]           acc_ff   [CORDIC_STAGES + 1];
   logic [ANGLE_W-1:0]         angle_ff;

   logic signed [CORDIC_W-1:0] x_pre, y_pre;

   assign x_pre = CORDIC_W'(in_x);
   assign y_pre = CORDIC_W'(in_y);

   always_ff @(posedge clock) begin
      if (x_pre < 0) begin
         x_ff[0]   <= -x_pre;
         y_ff[0]   <= -y_pre;
         acc_ff[0] <= HALF_TURN;
      end else begin
         x_ff[0]   <= x_pre;
         y_ff[0]   <= y_pre;
         acc_ff[0] <= '0;
      end
   end

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
      logic signed [CORDIC_W-1:0] x_c, y_c, xs_c, ys_c;
      logic [ACC_W-1:0]           a_c;

      // The rotation direction follows the sign of y before each step.
      always_comb begin
         x_c = x_ff[g];
         y_c = y_ff[g];
         a_c = acc_ff[g];
         for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            xs_c = x_c >>> (g * STEPS_PER_STAGE + s);
            ys_c = y_c >>> (g * STEPS_PER_STAGE + s);
            if (!y_c[CORDIC_W-1]) begin
               x_c = x_c + ys_c;
               y_c = y_c - xs_c;
               a_c = a_c + ATAN_TABLE[STEP_IDX_W'(g * STEPS_PER_STAGE + s)];
            end else begin
               x_c = x_c - ys_c;
               y_c = y_c + xs_c;
               a_c = a_c - ATAN_TABLE[STEP_IDX_W'(g * STEPS_PER_STAGE + s)];
            end
         end
      end

      always_ff @(posedge clock) begin
         x_ff[g+1]   <= x_c;
         y_ff[g+1]   <= y_c;
         acc_ff[g+1] <= a_c;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff <= ANGLE_W'((acc_ff[CORDIC_STAGES] + ACC_W'(8)) >> (ACC_W - ANGLE_W));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CORDIC_STAGES + 2; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < CORDIC_STAGES + 2; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[CORDIC_STAGES + 1];
   assign out_angle = angle_ff;

endmodule

>>> design/rthlp_hue_pick.sv
// ----------------------------------------------------------------------------
// rthlp_hue_pick: nearest hue entry and result register
// Compares the angle with the thirteen decision boundaries in parallel and
// maps the count to the hue entry; gray pixels give entry zero.
// ----------------------------------------------------------------------------
module rthlp_hue_pick (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [rthlp_pkg::ANGLE_W-1:0] in_angle,
   input  rthlp_pkg::side_type           in_side,
   output logic                          out_strobe,
   output logic [rthlp_pkg::HUE_W-1:0]   out_hue,
   output logic [rthlp_pkg::LUMA_W-1:0]  out_luma
);
   import rthlp_pkg::*;

   logic [HUE_NUM-2:0]   above;
   logic [HUE_POS_W-1:0] pos;
   logic [HUE_W-1:0]     hue_in, hue_ff;
   logic [LUMA_W-1:0]    luma_ff;
   logic                 strobe_ff;

   always_comb begin
      for (int k = 0; k < HUE_NUM - 1; k++) begin
         above[k] = (in_angle >= HUE_CUT[k]);
      end
      pos    = HUE_POS_W'($countones(above));
      hue_in = in_side.gray ? '0 : HUE_ORDER[pos];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      hue_ff  <= hue_in;
      luma_ff <= in_side.luma;
   end

   assign out_strobe = strobe_ff;
   assign out_hue    = hue_ff;
   assign out_luma   = luma_ff;

endmodule

>>> design/rgb_to_hue_luma_palette_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hue_luma_palette_top: RGB pixel to 15-hue by 16-luma palette entry
// Pipelined conversion of one pixel per clock into a hue entry (0 = gray)
// and a luma level, with a programmable gray threshold.
//
//   Channel   Ports                                Transfer
//   -------   ----------------------------------   ---------------------------
//   pixel     start, busy, req_red/green/blue      start high and busy low
//   result    rsp_strobe, rsp_hue_index/luma_idx   rsp_strobe high, one cycle
//   control   csr_write_enable, csr_write_data     csr_write_enable high
//
// A pixel is taken in every cycle; busy stays low. Each result comes out in
// order, after its pixel has passed the three-stage color conversion, the
// ten-stage CORDIC angle pipeline and the result register. Reset clears the
// pipeline valid bits and sets the gray threshold to 50. The receiver cannot
// stall, so nothing in the pipe ever waits.
// ----------------------------------------------------------------------------
module rgb_to_hue_luma_palette_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rthlp_pkg::COLOR_W-1:0] req_red,
   input  logic [rthlp_pkg::COLOR_W-1:0] req_green,
   input  logic [rthlp_pkg::COLOR_W-1:0] req_blue,
   output logic                          rsp_strobe,
   output logic [rthlp_pkg::HUE_W-1:0]   rsp_hue_index,
   output logic [rthlp_pkg::LUMA_W-1:0]  rsp_luma_index,
   input  logic                          csr_write_enable,
   input  logic [rthlp_pkg::THRESH_W-1:0] csr_write_data
);
   import rthlp_pkg::*;

   logic [CHROMA_W-1:0] bound_ff;
   logic                yuv_valid;
   yuv_type             yuv;
   side_type            side;
   logic                angle_valid;
   logic [ANGLE_W-1:0]  angle;

   assign busy = 1'b0;

   // The threshold is kept as its squared chroma bound, looked up on a write.
   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff <= GRAY_BOUND_TABLE[GRAY_THRESH_RESET];
      end else if (csr_write_enable) begin
         bound_ff <= GRAY_BOUND_TABLE[csr_write_data];
      end
   end

   rthlp_yuv u_yuv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .out_valid (yuv_valid),
      .out_yuv   (yuv)
   );

   rthlp_gray u_gray (
      .clock    (clock),
      .in_yuv   (yuv),
      .bound    (bound_ff),
      .out_side (side)
   );

   rthlp_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (yuv_valid),
      .in_x      (yuv.uq),
      .in_y      (yuv.vq),
      .out_valid (angle_valid),
      .out_angle (angle)
   );

   rthlp_hue_pick u_hue_pick (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (angle_valid),
      .in_angle   (angle),
      .in_side    (side),
      .out_strobe (rsp_strobe),
      .out_hue    (rsp_hue_index),
      .out_luma   (rsp_luma_index)
   );

endmodule

>>> bench/rgb_to_hue_luma_palette_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hue_luma_palette_checker: result predictor and scoreboard
// Watches the pixel, result and control channels of the palette converter.
// Every pixel transfer is turned into an expected hue entry and luma level by
// a bit-exact fixed-point model that uses the current gray threshold. Every
// result transfer is compared with the oldest expected entry.
// ----------------------------------------------------------------------------
module rgb_to_hue_luma_palette_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic [rthlp_pkg::COLOR_W-1:0]  req_red,
   input  logic [rthlp_pkg::COLOR_W-1:0]  req_green,
   input  logic [rthlp_pkg::COLOR_W-1:0]  req_blue,
   input  logic                           rsp_strobe,
   input  logic [rthlp_pkg::HUE_W-1:0]    rsp_hue_index,
   input  logic [rthlp_pkg::LUMA_W-1:0]   rsp_luma_index,
   input  logic                           csr_write_enable,
   input  logic [rthlp_pkg::THRESH_W-1:0] csr_write_data,
   output int                             fail_count,
   output int                             pending_count
);
   import rthlp_pkg::*;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [LUMA_W-1:0] luma;
   } palette_entry_type;

   // Arctangent of 2^-i in units of 2^-20 turn.
   localparam int unsigned STEP_TURN [16] = '{
      131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
      652, 326, 163, 81, 41, 20, 10, 5
   };

   // Hue entry angles as 16-bit binary angles; entry 0 (gray) is unused.
   localparam int HUE_ANGLE [15] = '{
      0, 24576, 20480, 16384, 12288, 8192, 4096, 61440,
      57344, 53248, 49152, 40960, 36864, 32768, 28672
   };

   palette_entry_type    expected_entries [$];
   palette_entry_type    oldest;
   logic [THRESH_W-1:0]  gray_threshold;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic longint scale_round(input longint value, input longint coef);
      longint prod;
      prod = value * coef;
      if (prod >= 0)
         return (prod + 32768) >>> 16;
      return -((-prod + 32768) >>> 16);
   endfunction

   function automatic logic [15:0] chroma_angle(input longint u, input longint v);
      logic [31:0] turn;
      longint      us;
      longint      vs;
      turn = '0;
      // Fold the left half plane over first; the vectoring steps only
      // converge for angles within a quarter turn of zero.
      if (u < 0) begin
         u    = -u;
         v    = -v;
         turn = 32'h8_0000;
      end
      for (int i = 0; i < 16; i++) begin
         us = u >>> i;
         vs = v >>> i;
         if (v >= 0) begin
            u    = u + vs;
            v    = v - us;
            turn = turn + STEP_TURN[i];
         end else begin
            u    = u - vs;
            v    = v + us;
            turn = turn - STEP_TURN[i];
         end
      end
      return 16'((turn + 32'd8) >> 4);
   endfunction

   function automatic palette_entry_type predict_palette_entry(
      input logic [COLOR_W-1:0]  red,
      input logic [COLOR_W-1:0]  green,
      input logic [COLOR_W-1:0]  blue,
      input logic [THRESH_W-1:0] threshold
   );
      longint            r, g, b, yq, uq, vq, distance, best;
      longint unsigned   chroma, scaled, bound;
      logic [15:0]       angle;
      palette_entry_type entry;
      r      = red;
      g      = green;
      b      = blue;
      yq     = 19595 * r + 38470 * g + 7471 * b;
      uq     = scale_round(b * 65536 - yq, 32244);
      vq     = scale_round(r * 65536 - yq, 57475);
      chroma = uq * uq + vq * vq;
      scaled = threshold;
      scaled = scaled * 255 * 65536;
      bound  = (scaled * scaled) / 64'd250000;
      entry.luma = yq[23:20];
      entry.hue  = '0;
      if (chroma > bound) begin
         angle = chroma_angle(uq, vq);
         best  = 131072;
         // No wrap-around in the distance, and a tie keeps the lower entry.
         for (int i = 1; i < 15; i++) begin
            distance = HUE_ANGLE[i] - longint'(angle);
            if (distance < 0)
               distance = -distance;
            if (distance < best) begin
               best      = distance;
               entry.hue = HUE_W'(i);
            end
         end
      end
      return entry;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_entries.delete();
         gray_threshold = GRAY_THRESH_RESET;
      end else begin
         if (start && !busy)
            expected_entries.push_back(
               predict_palette_entry(req_red, req_green, req_blue, gray_threshold));
         if (rsp_strobe) begin
            if (expected_entries.size() == 0) begin
               $error("result transfer with no pixel outstanding: hue_index %0d, luma_index %0d",
                      rsp_hue_index, rsp_luma_index);
               fail_count++;
            end else begin
               oldest = expected_entries.pop_front();
               if (rsp_hue_index !== oldest.hue) begin
                  $error("hue_index mismatch: expected %0d, actual %0d",
                         oldest.hue, rsp_hue_index);
                  fail_count++;
               end
               if (rsp_luma_index !== oldest.luma) begin
                  $error("luma_index mismatch: expected %0d, actual %0d",
                         oldest.luma, rsp_luma_index);
                  fail_count++;
               end
            end
         end
         if (csr_write_enable)
            gray_threshold = csr_write_data;
      end
      pending_count = expected_entries.size();
   end

endmodule

>>> bench/rgb_to_hue_luma_palette_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hue_luma_palette_top_tb: testbench for the RGB to palette converter
// Drives directed pixels (extremes, primaries, gray levels, angles near a full
// turn and in the gap between 225 and 270 degrees) and then phases of random
// pixels under several gray thresholds, with random sender gaps in all but the
// last phase. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module rgb_to_hue_luma_palette_top_tb;
   import rthlp_pkg::*;

   localparam int PHASES          = 8;
   localparam int PHASE_PIXELS    = 141;
   localparam int SETTLE_CYCLES   = 20;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [COLOR_W-1:0]  req_red;
   logic [COLOR_W-1:0]  req_green;
   logic [COLOR_W-1:0]  req_blue;
   logic                rsp_strobe;
   logic [HUE_W-1:0]    rsp_hue_index;
   logic [LUMA_W-1:0]   rsp_luma_index;
   logic                csr_write_enable;
   logic [THRESH_W-1:0] csr_write_data;
   int                  fail_count;
   int                  pending_count;
   bit                  gaps_enabled;

   always #2 clock = ~clock;

   rgb_to_hue_luma_palette_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .rsp_strobe       (rsp_strobe),
      .rsp_hue_index    (rsp_hue_index),
      .rsp_luma_index   (rsp_luma_index),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   rgb_to_hue_luma_palette_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .rsp_strobe       (rsp_strobe),
      .rsp_hue_index    (rsp_hue_index),
      .rsp_luma_index   (rsp_luma_index),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_pixel(input logic [COLOR_W-1:0] red, input logic [COLOR_W-1:0] green,
                             input logic [COLOR_W-1:0] blue);
      logic stalled;
      if (gaps_enabled && $urandom_range(0, 3) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      start     = 1'b1;
      req_red   = red;
      req_green = green;
      req_blue  = blue;
      do begin
         #1;
         stalled = busy;
         @(negedge clock);
      end while (stalled);
   endtask

   task automatic send_random_pixel();
      int               kind;
      int               base;
      int               level;
      logic [COLOR_W-1:0] comp [3];
      kind = $urandom_range(0, 99);
      base = $urandom_range(0, 255);
      for (int k = 0; k < 3; k++) begin
         if (kind < 40) begin
            comp[k] = COLOR_W'($urandom_range(0, 255));
         end else if (kind < 75) begin
            // Near-gray pixels put the chroma close to the gray bound.
            level = base + $urandom_range(0, 12) - 6;
            if (level < 0)
               level = 0;
            if (level > 255)
               level = 255;
            comp[k] = COLOR_W'(level);
         end else if (kind < 90) begin
            case ($urandom_range(0, 2))
               0:       comp[k] = '0;
               1:       comp[k] = '1;
               default: comp[k] = COLOR_W'($urandom_range(0, 255));
            endcase
         end else begin
            comp[k] = $urandom_range(0, 1) ? '1 : '0;
         end
      end
      send_pixel(comp[0], comp[1], comp[2]);
   endtask

   task automatic wait_for_drain();
      start = 1'b0;
      while (pending_count != 0)
         @(negedge clock);
   endtask

   task automatic set_gray_threshold(input logic [THRESH_W-1:0] value);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic logic [THRESH_W-1:0] phase_threshold(input int phase);
      case (phase)
         0:       return '0;
         1:       return '1;
         2:       return THRESH_W'(99);
         3:       return THRESH_W'(1);
         4:       return THRESH_W'(100);
         7:       return GRAY_THRESH_RESET;
         default: return THRESH_W'($urandom_range(0, 127));
      endcase
   endfunction

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_red          = '0;
      req_green        = '0;
      req_blue         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      gaps_enabled     = 1'b1;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed pixels under the reset threshold.
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd15, 8'd15, 8'd15);
      send_pixel(8'd16, 8'd16, 8'd16);
      send_pixel(8'd239, 8'd239, 8'd239);
      send_pixel(8'd240, 8'd240, 8'd240);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      // Blue-leaning pixels with a slight red deficit sit just under a full turn.
      send_pixel(8'd200, 8'd200, 8'd255);
      send_pixel(8'd150, 8'd170, 8'd255);
      // Green-leaning pixels land between the 225 and 270 degree entries.
      send_pixel(8'd0, 8'd200, 8'd100);
      send_pixel(8'd60, 8'd255, 8'd40);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd254, 8'd255, 8'd255);

      // Zero chroma must stay gray even with no threshold at all.
      set_gray_threshold('0);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd77, 8'd77, 8'd77);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd1, 8'd0, 8'd0);

      for (int phase = 0; phase < PHASES; phase++) begin
         set_gray_threshold(phase_threshold(phase));
         if (phase == PHASES - 1)
            gaps_enabled = 1'b0;
         repeat (PHASE_PIXELS) send_random_pixel();
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
